/* hw/rtl/lwt_pkg.sv */
// Shared constants, types and command/status bundles for the lookahead waypoint tracker.
package lwt_pkg;

    localparam int MAX_WP = 1024;
    localparam int AW     = $clog2(MAX_WP);
    localparam int CW     = AW + 1;
    localparam int WW     = ((CW > 11) ? CW : 11) + 1;
    localparam int OW     = 10;
    localparam int DIV_N  = 62;
    localparam int SQ_N   = 33;
    localparam int ACC_W  = 35;
    localparam int DCW    = $clog2(DIV_N + 1);

    typedef enum logic [2:0] {
        REG_CIRC  = 3'd0,
        REG_MIN   = 3'd1,
        REG_MAX   = 3'd2,
        REG_RATIO = 3'd3,
        REG_BACK  = 3'd4,
        REG_AHEAD = 3'd5
    } t_reg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_LOAD, S_EMPTY, S_QRY, S_MOD, S_MODF,
        S_NRD, S_NMX, S_NMY, S_NCMP, S_LKM, S_LKD, S_LKC,
        S_WRA, S_WLA, S_WCHK, S_WRB, S_WMX, S_WMY, S_WSUM, S_WSQ, S_WUPD, S_FIN
    } t_state;

    typedef enum logic [1:0] {
        RD_IDX   = 2'd0,
        RD_WCUR  = 2'd1,
        RD_WNEXT = 2'd2
    } t_rd_sel;

    typedef struct packed {
        logic    take;
        logic    wr;
        logic    q_init;
        logic    mod_set;
        logic    div_step;
        logic    rd;
        t_rd_sel rd_sel;
        logic    mx;
        logic    my;
        logic    ncmp;
        logic    lk_mul;
        logic    lk_set;
        logic    la;
        logic    wchk;
        logic    sq_init;
        logic    sq_step;
        logic    wupd;
        logic    emit;
        logic    emit_empty;
    } t_cmd;

    typedef struct packed {
        logic is_query;
        logic cnt_zero;
        logic need_mod;
        logic div_last;
        logic n_end;
        logic ratio_zero;
        logic w_stop;
        logic sq_last;
        logic wu_stop;
        logic out_free;
    } t_stat;

endpackage

/* hw/rtl/lwt_ctrl.sv */
// Sequencer for waypoint loads, nearest search, lookahead scaling and path walk.
module lwt_ctrl import lwt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_stall,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_DISP;
            S_DISP: begin
                if (!i_stat.is_query)     n_state = S_LOAD;
                else if (i_stat.cnt_zero) n_state = S_EMPTY;
                else                      n_state = S_QRY;
            end
            S_LOAD:  n_state = S_IDLE;
            S_EMPTY: if (i_stat.out_free) n_state = S_IDLE;
            S_QRY:   n_state = i_stat.need_mod ? S_MOD : S_NRD;
            S_MOD:   if (i_stat.div_last) n_state = S_MODF;
            S_MODF:  n_state = S_NRD;
            S_NRD:   n_state = S_NMX;
            S_NMX:   n_state = S_NMY;
            S_NMY:   n_state = S_NCMP;
            S_NCMP:  n_state = i_stat.n_end ? S_LKM : S_NRD;
            S_LKM:   n_state = i_stat.ratio_zero ? S_LKC : S_LKD;
            S_LKD:   if (i_stat.div_last) n_state = S_LKC;
            S_LKC:   n_state = S_WRA;
            S_WRA:   n_state = S_WLA;
            S_WLA:   n_state = S_WCHK;
            S_WCHK:  n_state = i_stat.w_stop ? S_FIN : S_WRB;
            S_WRB:   n_state = S_WMX;
            S_WMX:   n_state = S_WMY;
            S_WMY:   n_state = S_WSUM;
            S_WSUM:  n_state = S_WSQ;
            S_WSQ:   if (i_stat.sq_last) n_state = S_WUPD;
            S_WUPD:  n_state = i_stat.wu_stop ? S_FIN : S_WCHK;
            S_FIN:   if (i_stat.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.rd_sel = RD_IDX;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE:  o_cmd.take = i_in_valid;
            S_LOAD:  o_cmd.wr = 1'b1;
            S_EMPTY: begin
                o_cmd.emit       = i_stat.out_free;
                o_cmd.emit_empty = 1'b1;
            end
            S_QRY:   o_cmd.q_init = 1'b1;
            S_MOD:   o_cmd.div_step = 1'b1;
            S_MODF:  o_cmd.mod_set = 1'b1;
            S_NRD: begin
                o_cmd.rd     = 1'b1;
                o_cmd.rd_sel = RD_IDX;
            end
            S_NMX:   o_cmd.mx = 1'b1;
            S_NMY:   o_cmd.my = 1'b1;
            S_NCMP:  o_cmd.ncmp = 1'b1;
            S_LKM:   o_cmd.lk_mul = 1'b1;
            S_LKD:   o_cmd.div_step = 1'b1;
            S_LKC:   o_cmd.lk_set = 1'b1;
            S_WRA: begin
                o_cmd.rd     = 1'b1;
                o_cmd.rd_sel = RD_WCUR;
            end
            S_WLA:   o_cmd.la = 1'b1;
            S_WCHK:  o_cmd.wchk = 1'b1;
            S_WRB: begin
                o_cmd.rd     = 1'b1;
                o_cmd.rd_sel = RD_WNEXT;
            end
            S_WMX:   o_cmd.mx = 1'b1;
            S_WMY:   o_cmd.my = 1'b1;
            S_WSUM:  o_cmd.sq_init = 1'b1;
            S_WSQ:   o_cmd.sq_step = 1'b1;
            S_WUPD:  o_cmd.wupd = 1'b1;
            S_FIN:   o_cmd.emit = i_stat.out_free;
            default: o_cmd.take = 1'b0;
        endcase
    end

endmodule

/* hw/rtl/lwt_dp.sv */
// Datapath: waypoint memories, distance unit, divider, square root, walk state, result register.
module lwt_dp import lwt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic               i_op,
    input  logic               i_new_path,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic [30:0]        i_car_speed,
    input  logic               i_cfg_valid,
    input  logic [2:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_path_ready,
    output logic [OW-1:0]      o_nearest_idx,
    output logic [OW-1:0]      o_look_idx
);

    logic signed [31:0] r_mem_x [MAX_WP];
    logic signed [31:0] r_mem_y [MAX_WP];
    logic signed [31:0] r_q_x, r_q_y;

    logic        r_circ;
    logic [30:0] r_min, r_max, r_ratio;
    logic [9:0]  r_back, r_ahead;

    logic               r_op, r_newp;
    logic signed [31:0] r_car_x, r_car_y;
    logic [30:0]        r_speed;

    logic [CW-1:0] r_count;
    logic [AW-1:0] r_last;
    logic          r_known;

    logic signed [31:0] r_ax, r_ay, r_bx, r_by;
    logic [63:0]        r_sqx, r_sqy;
    logic [64:0]        r_best;
    logic [AW-1:0]      r_best_idx, r_idx, r_win_start;
    logic [WW-1:0]      r_rem;
    logic               r_seed;

    logic [30:0]    r_drem, r_dden;
    logic [61:0]    r_quo;
    logic [DCW-1:0] r_dcnt;

    logic [30:0]      r_target;
    logic [AW-1:0]    r_wcur;
    logic [CW-1:0]    r_steps;
    logic [ACC_W-1:0] r_acc;

    logic [65:0] r_rad;
    logic [32:0] r_sres;
    logic [35:0] r_srem;
    logic [5:0]  r_scnt;

    logic               r_out_valid, r_out_ready;
    logic [OW-1:0]      r_out_near, r_out_look;

    logic [AW-1:0]      rd_addr;
    logic signed [32:0] diff;
    logic [31:0]        mag;
    logic [64:0]        dsum;
    logic [CW-1:0]      idx_inc, wcur_inc;
    logic [AW-1:0]      idx_nx, wnext;
    logic               full_search;
    logic [WW-1:0]      last_w, cnt_w, start_w, end_w;
    logic [CW-1:0]      sbm, back;
    logic [31:0]        dt;
    logic               dge;
    logic [61:0]        t1;
    logic [30:0]        clamp_v;
    logic [35:0]        sr2, strial;
    logic               sge;

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_circ  <= 1'b1;
            r_min   <= 31'd32768;
            r_max   <= 31'd65536;
            r_ratio <= 31'd524288;
            r_back  <= 10'd10;
            r_ahead <= 10'd40;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_CIRC:  r_circ  <= i_cfg_data[0];
                REG_MIN:   r_min   <= i_cfg_data;
                REG_MAX:   r_max   <= i_cfg_data;
                REG_RATIO: r_ratio <= i_cfg_data;
                REG_BACK:  r_back  <= i_cfg_data[9:0];
                REG_AHEAD: r_ahead <= i_cfg_data[9:0];
                default:   r_circ  <= r_circ;
            endcase
        end
    end

    // memories
    always_comb begin
        case (i_cmd.rd_sel)
            RD_WCUR:  rd_addr = r_wcur;
            RD_WNEXT: rd_addr = wnext;
            default:  rd_addr = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && (r_newp || (r_count < CW'(MAX_WP)))) begin
            r_mem_x[r_newp ? '0 : r_count[AW-1:0]] <= r_car_x;
            r_mem_y[r_newp ? '0 : r_count[AW-1:0]] <= r_car_y;
        end
        if (i_cmd.rd) begin
            r_q_x <= r_mem_x[rd_addr];
            r_q_y <= r_mem_y[rd_addr];
        end
    end

    // combinational helpers
    always_comb begin
        diff     = i_cmd.mx ? ({r_ax[31], r_ax} - {r_q_x[31], r_q_x})
                            : ({r_ay[31], r_ay} - {r_q_y[31], r_q_y});
        mag      = diff[32] ? 32'(-diff) : 32'(diff);
        dsum     = {1'b0, r_sqx} + {1'b0, r_sqy};
        idx_inc  = {1'b0, r_idx} + CW'(1);
        idx_nx   = (idx_inc == r_count) ? '0 : idx_inc[AW-1:0];
        wcur_inc = {1'b0, r_wcur} + CW'(1);
        if (r_circ) begin
            wnext = (wcur_inc == r_count) ? '0 : wcur_inc[AW-1:0];
        end else begin
            wnext = (wcur_inc < r_count) ? wcur_inc[AW-1:0] : AW'(r_count - CW'(1));
        end
        full_search = !r_known || ({1'b0, r_last} >= r_count);
        last_w  = WW'(r_last);
        cnt_w   = WW'(r_count);
        start_w = (last_w > WW'(r_back)) ? (last_w - WW'(r_back)) : '0;
        end_w   = ((last_w + WW'(r_ahead)) > (cnt_w - WW'(1))) ? (cnt_w - WW'(1))
                                                               : (last_w + WW'(r_ahead));
        sbm     = CW'(r_drem);
        back    = ({1'b0, r_last} >= sbm) ? ({1'b0, r_last} - sbm)
                                          : ({1'b0, r_last} + r_count - sbm);
        dt      = {r_drem, r_quo[61]};
        dge     = (dt >= {1'b0, r_dden});
        t1      = (r_quo < 62'(r_min)) ? 62'(r_min) : r_quo;
        clamp_v = (t1 > 62'(r_max)) ? r_max : t1[30:0];
        sr2     = {r_srem[33:0], r_rad[65:64]};
        strial  = {1'b0, r_sres, 2'b01};
        sge     = (sr2 >= strial);
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op    <= i_op;
            r_newp  <= i_new_path;
            r_car_x <= i_pos_x;
            r_car_y <= i_pos_y;
            r_speed <= i_car_speed;
        end
        if (i_cmd.q_init) begin
            r_ax   <= r_car_x;
            r_ay   <= r_car_y;
            r_seed <= 1'b1;
            if (full_search) begin
                r_idx       <= '0;
                r_win_start <= AW'(1);
                r_rem       <= WW'(r_count - CW'(1));
            end else begin
                r_idx <= r_last;
                if (r_circ) begin
                    r_rem  <= WW'({1'b0, r_back} + {1'b0, r_ahead});
                    r_quo  <= 62'(r_back);
                    r_drem <= '0;
                    r_dden <= 31'(r_count);
                    r_dcnt <= DCW'(DIV_N);
                end else begin
                    r_win_start <= AW'(start_w);
                    r_rem       <= end_w - start_w + WW'(1);
                end
            end
        end
        if (i_cmd.div_step) begin
            r_drem <= dge ? 31'(dt - {1'b0, r_dden}) : dt[30:0];
            r_quo  <= {r_quo[60:0], dge};
            r_dcnt <= r_dcnt - DCW'(1);
        end
        if (i_cmd.mod_set) begin
            r_win_start <= back[AW-1:0];
        end
        if (i_cmd.mx) begin
            r_sqx <= 64'(mag) * 64'(mag);
            r_bx  <= r_q_x;
            r_by  <= r_q_y;
        end
        if (i_cmd.my) begin
            r_sqy <= 64'(mag) * 64'(mag);
        end
        if (i_cmd.ncmp) begin
            if (r_seed || (dsum < r_best)) begin
                r_best     <= dsum;
                r_best_idx <= r_idx;
            end
            if (r_seed) begin
                r_idx  <= r_win_start;
                r_seed <= 1'b0;
            end else begin
                r_idx <= idx_nx;
                r_rem <= r_rem - WW'(1);
            end
        end
        if (i_cmd.lk_mul) begin
            r_quo  <= 62'(r_max) * 62'(r_speed);
            r_drem <= '0;
            r_dden <= r_ratio;
            r_dcnt <= DCW'(DIV_N);
        end
        if (i_cmd.lk_set) begin
            r_target <= (r_ratio == '0) ? r_max : clamp_v;
            r_wcur   <= r_best_idx;
            r_steps  <= '0;
            r_acc    <= '0;
        end
        if (i_cmd.la) begin
            r_ax <= r_q_x;
            r_ay <= r_q_y;
        end
        if (i_cmd.wchk && r_circ) begin
            r_steps <= r_steps + CW'(1);
        end
        if (i_cmd.sq_init) begin
            r_rad  <= {1'b0, dsum};
            r_sres <= '0;
            r_srem <= '0;
            r_scnt <= 6'(SQ_N);
        end
        if (i_cmd.sq_step) begin
            r_srem <= sge ? (sr2 - strial) : sr2;
            r_sres <= {r_sres[31:0], sge};
            r_rad  <= {r_rad[63:0], 2'b00};
            r_scnt <= r_scnt - 6'd1;
        end
        if (i_cmd.wupd) begin
            if (r_sres != '0) begin
                r_acc <= r_acc + ACC_W'(r_sres);
            end
            if (r_circ || (r_sres != '0)) begin
                r_wcur <= wnext;
                r_ax   <= r_bx;
                r_ay   <= r_by;
            end
        end
        if (i_cmd.emit) begin
            r_out_ready <= !i_cmd.emit_empty;
            r_out_near  <= i_cmd.emit_empty ? '0 : OW'(r_best_idx);
            r_out_look  <= i_cmd.emit_empty ? '0 : OW'(r_wcur);
        end
    end

    // path bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_last  <= '0;
            r_known <= 1'b0;
        end else if (i_cmd.wr) begin
            if (r_newp) begin
                r_count <= CW'(1);
            end else if (r_count < CW'(MAX_WP)) begin
                r_count <= r_count + CW'(1);
            end
            r_last  <= '0;
            r_known <= 1'b0;
        end else if (i_cmd.lk_mul) begin
            r_last  <= r_best_idx;
            r_known <= 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_stat.is_query   = r_op;
        o_stat.cnt_zero   = (r_count == '0);
        o_stat.need_mod   = !full_search && r_circ;
        o_stat.div_last   = (r_dcnt == DCW'(1));
        o_stat.n_end      = r_seed ? (r_rem == '0) : (r_rem == WW'(1));
        o_stat.ratio_zero = (r_ratio == '0);
        o_stat.w_stop     = (r_acc >= ACC_W'(r_target))
                         || (r_circ && (r_steps >= r_count))
                         || (wnext == r_wcur);
        o_stat.sq_last    = (r_scnt == 6'd1);
        o_stat.wu_stop    = !r_circ && ((r_sres == '0)
                                     || ({1'b0, wnext} >= (r_count - CW'(1))));
        o_stat.out_free   = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid   = r_out_valid;
    assign o_path_ready  = r_out_ready;
    assign o_nearest_idx = r_out_near;
    assign o_look_idx    = r_out_look;

endmodule

/* hw/rtl/lookahead_waypoint_tracker.sv */
// Top level of the lookahead waypoint tracker: controller plus datapath.
//
//   channel  direction  handshake               payload
//   in       sink       i_in_valid/o_in_stall   op, new_path, pos_x, pos_y, car_speed
//   out      source     o_out_valid/i_out_stall path_ready, nearest_idx, look_idx
//   cfg      sink       i_cfg_valid/o_cfg_ready index (3 bit), data (31 bit)
//
// A query searches the window for the nearest waypoint, divides for the lookahead distance
// and then walks segments, summing their lengths by square root; a zero ratio skips the
// division, and a warm circular search runs one more division for the window start. The
// shared restoring divider, the bit-serial square root and the single memory read port
// serve all of these steps.
// Reset is synchronous; the waypoint memories are not cleared. A new beat is taken
// while a finished result still waits under i_out_stall.
module lookahead_waypoint_tracker import lwt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_op,
    input  logic               i_new_path,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic [30:0]        i_car_speed,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_path_ready,
    output logic [OW-1:0]      o_nearest_idx,
    output logic [OW-1:0]      o_look_idx,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    lwt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    lwt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_op          (i_op),
        .i_new_path    (i_new_path),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_car_speed   (i_car_speed),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_path_ready  (o_path_ready),
        .o_nearest_idx (o_nearest_idx),
        .o_look_idx    (o_look_idx)
    );

endmodule
